// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the coast and perimeter block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== src/bgcp_pkg.sv =====
// Types, constants and helper functions of the coast and perimeter block
`default_nettype none

package bgcp_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 1;

  // Result field widths
  localparam int POS_W  = 6;
  localparam int LAND_W = 13;
  localparam int EDGE_W = 14;
  localparam int AREA_W = 13;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QCW    = 3;

  // One result item as held in the queue
  typedef struct packed {
    logic [AREA_W-1:0] total_area;
    logic [EDGE_W-1:0] perim_total;
    logic [LAND_W-1:0] land_total;
    logic              map_done;
    logic              run_last;
    logic              is_coast;
    logic [POS_W-1:0]  cell_col;
    logic [POS_W-1:0]  cell_row;
  } res_t;

  // Number of sides of a land cell that face water or the outside
  function automatic logic [2:0] wet_sides(input logic self, input logic up,
                                           input logic down, input logic left,
                                           input logic right);
    logic [2:0] n;
    n = {2'b00, ~up} + {2'b00, ~down} + {2'b00, ~left} + {2'b00, ~right};
    return self ? n : 3'd0;
  endfunction

  // Saturating add of a small increment to the perimeter count
  function automatic logic [EDGE_W-1:0] edge_add(input logic [EDGE_W-1:0] base,
                                                 input logic [3:0] inc);
    logic [EDGE_W:0] s;
    s = {1'b0, base} + (EDGE_W+1)'(inc);
    return s[EDGE_W] ? {EDGE_W{1'b1}} : s[EDGE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/binary_grid_coast_and_perimeter.sv =====
// Top level: raster-order coast finder with land and wet-perimeter counters
`default_nettype none
`include "assert_macros.svh"

// Cells enter one per item in raster order; each cell's coast flag leaves with
// its coordinates once its four neighbours are known, together with the running
// land count, the saturating wet perimeter and the grid area. An item is taken
// every cycle while it causes at most one result and the output does not stall:
// rows after the first and above the last give one result each (the cell above).
// In the last row each item after the first also reports the cell to its left and
// the final cell reports itself as well, so an item there gives up to two results
// and the final cell up to three; the single output port, draining a four-entry
// result queue, then sets the pace. The previous rows live in a MAX_COLS x 2 line
// memory (one bit per row parity) with two registered read ports; read data is
// fetched ahead from the next position and a same-entry write is forwarded. The
// line memory needs no clearing pass: only entries written earlier in the same
// grid are used. Writing either configuration register restarts the grid at (0,0).
module binary_grid_coast_and_perimeter #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write port
  input  wire logic                            cfg_we_i,
  input  wire logic [bgcp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bgcp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input cells
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // [0] is_land, [7:1] zero
  input  wire logic [bgcp_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // results
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [5:0] cell_row, [11:6] cell_col, [12] is_coast, [25:13] land_total,
  // [39:26] perim_total, [52:40] total_area, [55:53] zero
  output      logic [bgcp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // run_last
  output      logic                            m_axis_tlast,
  // [0] map_done
  output      logic [bgcp_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
  import bgcp_pkg::*;

  localparam int CW  = $clog2(MAX_COLS);
  localparam int RW  = $clog2(MAX_ROWS);
  localparam int CCW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;
  localparam int RCW = (RW > CFG_DATA_W) ? RW : CFG_DATA_W;

  // Configuration registers and effective dimensions
  logic [CFG_DATA_W-1:0] grid_rows_q, grid_cols_q;
  logic [CFG_DATA_W-1:0] rows_eff, cols_eff, rows_m1, cols_m1;
  logic [2*CFG_DATA_W-1:0] area_full;

  always_comb begin
    rows_eff = grid_rows_q;
    if (grid_rows_q == '0) begin
      rows_eff = CFG_DATA_W'(1);
    end else if (32'(grid_rows_q) > MAX_ROWS) begin
      rows_eff = CFG_DATA_W'(MAX_ROWS);
    end
    cols_eff = grid_cols_q;
    if (grid_cols_q == '0) begin
      cols_eff = CFG_DATA_W'(1);
    end else if (32'(grid_cols_q) > MAX_COLS) begin
      cols_eff = CFG_DATA_W'(MAX_COLS);
    end
    rows_m1   = rows_eff - CFG_DATA_W'(1);
    cols_m1   = cols_eff - CFG_DATA_W'(1);
    area_full = (2*CFG_DATA_W)'(rows_eff) * (2*CFG_DATA_W)'(cols_eff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= CFG_DATA_W'(64);
      grid_cols_q <= CFG_DATA_W'(64);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        REG_GRID_COLS: grid_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Position and counters
  logic [RW-1:0]     row_q, row_d, row_nx;
  logic [CW-1:0]     col_q, col_d, col_nx;
  logic [LAND_W-1:0] land_q, land_base, land_new;
  logic [EDGE_W-1:0] edge_q, edge_base;
  logic              acc, land_in, first, last_row, last_col;
  logic              r_ge1, r_ge2, c_ge1, c_ge2;

  assign acc      = s_axis_tvalid && s_axis_tready;
  assign land_in  = s_axis_tdata[0];
  assign first    = (row_q == '0) && (col_q == '0);
  assign last_row = RCW'(row_q) == RCW'(rows_m1);
  assign last_col = CCW'(col_q) == CCW'(cols_m1);
  assign r_ge1    = row_q != '0;
  assign r_ge2    = r_ge1 && (row_q != RW'(1));
  assign c_ge1    = col_q != '0;
  assign c_ge2    = c_ge1 && (col_q != CW'(1));

  // Raster advance, restart on any configuration write
  always_comb begin
    col_nx = last_col ? '0 : col_q + CW'(1);
    row_nx = row_q;
    if (last_col) begin
      row_nx = last_row ? '0 : row_q + RW'(1);
    end
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end else if (acc) begin
      col_d = col_nx;
      row_d = row_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Line memory: bit [parity] holds the cell of the last row of that parity
  logic [1:0]    line_mem_q [MAX_COLS];
  logic [1:0]    rd_a_q, rd_b_q, wdat_q, a_word, b_word, wdata;
  logic [CW-1:0] rd_addr_a, rd_addr_b;
  logic          fwd_a_q, fwd_b_q;

  assign rd_addr_a = col_d;
  assign rd_addr_b = col_d + CW'(1);

  always_ff @(posedge clk_i) begin
    if (acc) begin
      line_mem_q[col_q] <= wdata;
    end
    rd_a_q <= line_mem_q[rd_addr_a];
    rd_b_q <= line_mem_q[rd_addr_b];
    if (acc) begin
      wdat_q <= wdata;
    end
  end

  // Forward a write that hit the entry read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      fwd_a_q <= acc && (col_q == rd_addr_a);
      fwd_b_q <= acc && (col_q == rd_addr_b);
    end
  end

  assign a_word = fwd_a_q ? wdat_q : rd_a_q;
  assign b_word = fwd_b_q ? wdat_q : rd_b_q;

  // Neighbour bits seen from the current position
  logic up_prev, up_two, up_right;
  logic prev_up_q, prev_land_q, prev2_land_q;

  assign up_prev  = row_q[0] ? a_word[0] : a_word[1];
  assign up_two   = row_q[0] ? a_word[1] : a_word[0];
  assign up_right = row_q[0] ? b_word[0] : b_word[1];
  assign wdata    = row_q[0] ? {land_in, a_word[0]} : {a_word[1], land_in};

  always_ff @(posedge clk_i) begin
    if (acc) begin
      prev_up_q    <= up_prev;
      prev_land_q  <= land_in;
      prev2_land_q <= prev_land_q;
    end
  end

  // Three possible results: cell above, cell to the left, current cell
  logic       v1, v2, v3;
  logic [2:0] w1, w2, w3;
  logic [3:0] s1, s2, s3;

  assign v1 = r_ge1;
  assign v2 = last_row && c_ge1;
  assign v3 = last_row && last_col;

  assign w1 = v1 ? wet_sides(up_prev, r_ge2 && up_two, land_in,
                             c_ge1 && prev_up_q, !last_col && up_right) : 3'd0;
  assign w2 = v2 ? wet_sides(prev_land_q, r_ge1 && prev_up_q, 1'b0,
                             c_ge2 && prev2_land_q, land_in) : 3'd0;
  assign w3 = v3 ? wet_sides(land_in, r_ge1 && up_prev, 1'b0,
                             c_ge1 && prev_land_q, 1'b0) : 3'd0;

  assign s1 = {1'b0, w1};
  assign s2 = s1 + {1'b0, w2};
  assign s3 = s2 + {1'b0, w3};

  assign land_base = first ? '0 : land_q;
  assign edge_base = first ? '0 : edge_q;
  assign land_new  = (land_in && !(&land_base)) ? land_base + LAND_W'(1) : land_base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      land_q <= '0;
      edge_q <= '0;
    end else if (acc) begin
      land_q <= land_new;
      edge_q <= edge_add(edge_base, s3);
    end
  end

  res_t res1, res2, res3;

  always_comb begin
    res1.cell_row      = POS_W'(row_q - RW'(1));
    res1.cell_col      = POS_W'(col_q);
    res1.is_coast      = w1 != 3'd0;
    res1.run_last      = !v2 && !v3;
    res1.map_done      = 1'b0;
    res1.land_total    = land_new;
    res1.perim_total   = edge_add(edge_base, s1);
    res1.total_area    = area_full[AREA_W-1:0];

    res2.cell_row      = POS_W'(row_q);
    res2.cell_col      = POS_W'(col_q - CW'(1));
    res2.is_coast      = w2 != 3'd0;
    res2.run_last      = !v3;
    res2.map_done      = 1'b0;
    res2.land_total    = land_new;
    res2.perim_total   = edge_add(edge_base, s2);
    res2.total_area    = area_full[AREA_W-1:0];

    res3.cell_row      = POS_W'(row_q);
    res3.cell_col      = POS_W'(col_q);
    res3.is_coast      = w3 != 3'd0;
    res3.run_last      = 1'b1;
    res3.map_done      = 1'b1;
    res3.land_total    = land_new;
    res3.perim_total   = edge_add(edge_base, s3);
    res3.total_area    = area_full[AREA_W-1:0];
  end

  // Result queue: up to three pushes per item, one pop per cycle
  res_t           queue_q [QDEPTH];
  logic [QAW-1:0] head_q, tail_q, off2, off3;
  logic [QCW-1:0] count_q;
  logic [1:0]     n_push;
  logic           pop;

  assign off2   = QAW'(v1);
  assign off3   = QAW'(v1) + QAW'(v2);
  assign n_push = 2'(v1) + 2'(v2) + 2'(v3);
  assign pop    = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (v1) begin
        queue_q[tail_q] <= res1;
      end
      if (v2) begin
        queue_q[tail_q + off2] <= res2;
      end
      if (v3) begin
        queue_q[tail_q + off3] <= res3;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      if (pop) begin
        head_q <= head_q + QAW'(1);
      end
      if (acc) begin
        tail_q <= tail_q + QAW'(n_push);
      end
      count_q <= count_q + (acc ? QCW'(n_push) : '0) - QCW'(pop);
    end
  end

  // Room for a full burst of three results
  assign s_axis_tready = count_q < QCW'(QDEPTH - 2);

  // Output side
  res_t head_res;
  assign head_res      = queue_q[head_q];
  assign m_axis_tvalid = count_q != '0;
  assign m_axis_tlast  = head_res.run_last;
  assign m_axis_tuser  = head_res.map_done;
  assign m_axis_tdata  = {3'b000, head_res.total_area, head_res.perim_total,
                          head_res.land_total, head_res.is_coast,
                          head_res.cell_col, head_res.cell_row};

  // Checks
  `ASSERT_IMPLIES(a_queue_bound, clk_i, rst_ni, 1'b1, count_q <= QCW'(QDEPTH))
  `ASSERT_IMPLIES(a_done_ends_run, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
  `ASSERT_NEXT(a_wrap_after_grid, clk_i, rst_ni, acc && last_row && last_col, first)
  `ASSERT_IMPLIES(a_col_in_grid, clk_i, rst_ni, 1'b1, CCW'(col_q) <= CCW'(cols_m1))

endmodule

`default_nettype wire

// ===== test/tb_binary_grid_coast_and_perimeter.sv =====
// Self-checking stream testbench for the raster-order coast and perimeter block
`default_nettype none

module tb_binary_grid_coast_and_perimeter;
  import bgcp_pkg::*;

  localparam int GRID_MAX     = 64;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RAND_ITEMS   = 113;
  localparam logic [LAND_W-1:0] LAND_MAX = {LAND_W{1'b1}};
  localparam logic [EDGE_W-1:0] EDGE_MAX = {EDGE_W{1'b1}};

  // One queued input item plus a flag to pause the sender until results drain
  typedef struct packed {
    logic land;
    logic drain_first;
  } cell_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;

  binary_grid_coast_and_perimeter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Stimulus and scoreboard state
  cell_item_t  cell_fifo [$];
  res_t        coast_expected [$];
  int          err_count = 0;
  int          cycle_count = 0;
  bit          in_fire = 1'b0;
  bit          out_fire = 1'b0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  int          in_gap = 0;
  int          out_stall = 0;
  int          hold_left = 0;
  int          hold_asks = 0;
  int          hold_taken = 0;

  // Shadow of the block: two rows of cells by row parity, position, counters
  logic              line_bits [2][GRID_MAX] = '{default: 1'b0};
  int unsigned       next_row = 0;
  int unsigned       next_col = 0;
  logic [LAND_W-1:0] land_cnt = '0;
  logic [EDGE_W-1:0] edge_cnt = '0;
  logic [6:0]        rows_cfg = 7'd64;
  logic [6:0]        cols_cfg = 7'd64;

  // Out-of-range sizes: zero acts as one, too large acts as the maximum
  function automatic int unsigned eff_dim(input logic [6:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX) return GRID_MAX;
    return v;
  endfunction

  // Judge one cell from its neighbors and add its wet sides to the perimeter
  task automatic judge_cell(input int unsigned r, input int unsigned c, input logic self,
                            input logic up, input logic down, input logic left,
                            input logic right, output res_t res);
    int unsigned wet;
    int unsigned sum;
    res = '0;
    wet = 0;
    if (self) begin
      wet = (up ? 0 : 1) + (down ? 0 : 1) + (left ? 0 : 1) + (right ? 0 : 1);
      sum = edge_cnt + wet;
      edge_cnt = (sum > EDGE_MAX) ? EDGE_MAX : EDGE_W'(sum);
    end
    res.cell_row = POS_W'(r);
    res.cell_col = POS_W'(c);
    res.is_coast = self && (wet > 0);
    res.perim_total = edge_cnt;
  endtask

  // A last-row cell: nothing below, all else already stored
  task automatic judge_last_row(input int unsigned r, input int unsigned c,
                                input int unsigned cols, output res_t res);
    judge_cell(r, c, line_bits[r % 2][c],
               (r >= 1) ? line_bits[(r + 1) % 2][c] : 1'b0, 1'b0,
               (c >= 1) ? line_bits[r % 2][c - 1] : 1'b0,
               (c + 1 < cols) ? line_bits[r % 2][c + 1] : 1'b0, res);
  endtask

  // Expected results of one accepted cell, in output order
  task automatic predict_coast(input logic land);
    res_t        found [$];
    res_t        res;
    int unsigned rows, cols, r, c, pr;
    rows = eff_dim(rows_cfg);
    cols = eff_dim(cols_cfg);
    r = next_row;
    c = next_col;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
    end
    // a new grid starts its counts afresh
    if (r == 0 && c == 0) begin
      land_cnt = '0;
      edge_cnt = '0;
    end
    if (land && land_cnt < LAND_MAX) land_cnt++;
    // the cell above is now complete
    if (r >= 1) begin
      pr = (r - 1) % 2;
      judge_cell(r - 1, c, line_bits[pr][c],
                 (r >= 2) ? line_bits[r % 2][c] : 1'b0, land,
                 (c >= 1) ? line_bits[pr][c - 1] : 1'b0,
                 (c + 1 < cols) ? line_bits[pr][c + 1] : 1'b0, res);
      found.push_back(res);
    end
    line_bits[r % 2][c] = land;
    // last row: the cell to the left, and at the row end this one too
    if (r == rows - 1) begin
      if (c >= 1) begin
        judge_last_row(r, c - 1, cols, res);
        found.push_back(res);
      end
      if (c == cols - 1) begin
        judge_last_row(r, c, cols, res);
        found.push_back(res);
      end
    end
    foreach (found[k]) begin
      found[k].land_total = land_cnt;
      found[k].total_area = AREA_W'(rows * cols);
    end
    if (found.size() > 0) begin
      found[found.size() - 1].run_last = 1'b1;
      found[found.size() - 1].map_done = (r == rows - 1) && (c == cols - 1);
    end
    foreach (found[k]) coast_expected.push_back(found[k]);
    // advance, wrapping after the last cell
    if (c + 1 < cols) begin
      next_col = c + 1;
      next_row = r;
    end else begin
      next_col = 0;
      next_row = (r + 1 < rows) ? r + 1 : 0;
    end
  endtask

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    err_count++;
  endtask

  // Compare one accepted result with the oldest expectation
  task automatic check_coast_result();
    res_t  want;
    string at;
    if (coast_expected.size() == 0) begin
      flag_mismatch("result with nothing expected, cell_row", m_axis_tdata[5:0], 0);
      return;
    end
    want = coast_expected.pop_front();
    at = $sformatf("cell (%0d,%0d)", want.cell_row, want.cell_col);
    if (m_axis_tdata[5:0] != want.cell_row)
      flag_mismatch({at, " cell_row"}, m_axis_tdata[5:0], want.cell_row);
    if (m_axis_tdata[11:6] != want.cell_col)
      flag_mismatch({at, " cell_col"}, m_axis_tdata[11:6], want.cell_col);
    if (m_axis_tdata[12] != want.is_coast)
      flag_mismatch({at, " is_coast"}, m_axis_tdata[12], want.is_coast);
    if (m_axis_tdata[25:13] != want.land_total)
      flag_mismatch({at, " land_total"}, m_axis_tdata[25:13], want.land_total);
    if (m_axis_tdata[39:26] != want.perim_total)
      flag_mismatch({at, " perim_total"}, m_axis_tdata[39:26], want.perim_total);
    if (m_axis_tdata[52:40] != want.total_area)
      flag_mismatch({at, " total_area"}, m_axis_tdata[52:40], want.total_area);
    if (m_axis_tlast != want.run_last)
      flag_mismatch({at, " run_last"}, m_axis_tlast, want.run_last);
    if (m_axis_tuser[0] != want.map_done)
      flag_mismatch({at, " map_done"}, m_axis_tuser[0], want.map_done);
  endtask

  // Sample both handshakes at the rising edge
  always @(posedge clk_i) begin
    in_fire = s_axis_tvalid && s_axis_tready;
    out_fire = m_axis_tvalid && m_axis_tready;
    if (in_fire) predict_coast(s_axis_tdata[0]);
    if (out_fire) check_coast_result();
  end

  // Cell driver: next item once the previous one is taken and its gap is over
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (cell_fifo.size() > 0 &&
                   !(cell_fifo[0].drain_first && coast_expected.size() > 0)) begin
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, cell_fifo[0].land};
        s_axis_tvalid <= 1'b1;
        void'(cell_fifo.pop_front());
        in_gap = in_idle_on ? $urandom_range(0, 10) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stall per item, plus a long hold on request
  always @(negedge clk_i) begin
    if (hold_asks != hold_taken) begin
      hold_taken = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (out_fire) out_stall = out_idle_on ? $urandom_range(0, 10) : 0;
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Block idle: nothing queued or offered, every result in, then a short pause
  task automatic wait_idle();
    while (cell_fifo.size() != 0 || s_axis_tvalid || coast_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write; any write restarts the grid at the first cell
  task automatic write_grid_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_GRID_ROWS) rows_cfg = val;
    else cols_cfg = val;
    next_row = 0;
    next_col = 0;
  endtask

  task automatic set_grid(input logic [6:0] rows_val, input logic [6:0] cols_val);
    write_grid_reg(REG_GRID_ROWS, rows_val);
    write_grid_reg(REG_GRID_COLS, cols_val);
  endtask

  // Directed cells: 'L' land, 'W' water
  task automatic queue_pattern(input string pat);
    cell_item_t it;
    for (int i = 0; i < pat.len(); i++) begin
      it.land = (pat[i] == "L");
      it.drain_first = 1'b0;
      cell_fifo.push_back(it);
    end
  endtask

  task automatic queue_random(input int count, input int land_pct, input int drain_at);
    cell_item_t it;
    for (int i = 0; i < count; i++) begin
      it.land = ($urandom_range(0, 99) < land_pct);
      it.drain_first = (i == drain_at);
      cell_fifo.push_back(it);
    end
  endtask

  function automatic int pick_density();
    case ($urandom_range(0, 3))
      0: return 10;
      1: return 90;
      default: return 50;
    endcase
  endfunction

  initial begin
    int rows_val, cols_val, cells, count, sent;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset size, a partial first row, then a restart by register write
    queue_pattern("LW");
    wait_idle();
    // zero rows acts as one: a single row of three
    set_grid(7'd0, 7'd3);
    queue_pattern("LWL");
    wait_idle();
    // partial grid left behind by the next write
    write_grid_reg(REG_GRID_ROWS, 7'd2);
    queue_pattern("WLW");
    wait_idle();
    // zero columns acts as one
    write_grid_reg(REG_GRID_COLS, 7'd0);
    queue_pattern("LL");
    wait_idle();
    // all land: only the center is inland
    set_grid(7'd3, 7'd3);
    queue_pattern("LLLLLLLLL");
    wait_idle();

    // tallest grid, one column; receiver holds off and the sender stalls once
    set_grid(7'd64, 7'd1);
    hold_asks++;
    queue_random(64, 50, 32);
    wait_idle();
    // widest grid, one row, oversized column value
    set_grid(7'd1, 7'd127);
    queue_random(64, pick_density(), -1);
    wait_idle();

    // random small grids, one or more back to back per setting
    sent = 0;
    while (sent < RAND_ITEMS) begin
      rows_val = $urandom_range(1, 8);
      cols_val = $urandom_range(1, 8);
      cells = rows_val * cols_val;
      count = cells * $urandom_range(1, 2) + $urandom_range(0, cells - 1);
      // the last setting is trimmed to keep the run near its item budget
      if (count > RAND_ITEMS - sent) count = RAND_ITEMS - sent;
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      set_grid(7'(rows_val), 7'(cols_val));
      queue_random(count, pick_density(), $urandom_range(0, 1) ? count / 2 : -1);
      wait_idle();
      sent += count;
    end

    wait_idle();
    if (err_count == 0 && coast_expected.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/bgcp_pkg.sv
src/binary_grid_coast_and_perimeter.sv
test/tb_binary_grid_coast_and_perimeter.sv
